@@ hdl/trie_pkg.sv @@
// Shared constants and codes for the trie insert and walk unit.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package trie_pkg;

    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int POOL_NODES_DEF    = 1024;
    localparam int COUNT_BITS_DEF    = 16;

    localparam int SENTINEL_ID    = 0;
    localparam int ROOT_ID        = 1;
    localparam int FIRST_FREE_ID  = 2;
    localparam int SENTINEL_DEPTH = -1;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_INSERT = 2'd0;
    localparam t_opcode OP_QCHILD = 2'd1;
    localparam t_opcode OP_QNODE  = 2'd2;
    localparam t_opcode OP_CLEAR  = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_SYM  = 2'd2;
    localparam t_status ST_NODE = 2'd3;

endpackage

@@ hdl/trie_insert_and_walk_unit.sv @@
// Top level of the trie insert and walk unit: sequencer, node registers and two RAMs.
// Depends on trie_pkg and trie_ram.
`timescale 1ns / 1ps

// The unit keeps a prefix tree in a fixed pool of nodes. Requests enter on the
// input channel (i_in_valid, o_in_stall) and each one yields exactly one result
// on the output channel (o_out_valid, i_out_stall), in order.
// A request is taken only while the sequencer is idle; a result waiting in the
// output register does not block the next request, but the sequencer holds
// before its own result until the output register frees up.
// States per request, from its acceptance to the earliest next acceptance:
//   insert that allocates a node or finds the pool full: S_CHILD; query node:
//   S_INFO; symbol or node error: S_FAST; insert that follows an existing edge,
//   query child: S_CHILD, then S_INFO; clear: S_FAST, then the sweep described below.
// The result is registered as the sequencer returns to idle, except after a clear,
// whose sweep follows its result. Edge-following inserts and child queries read
// the child table, then node info: synchronous RAMs, each with a registered read.
// Reset is synchronous and active low. After reset, and after every clear
// request, the child table is swept to zero, all POOL_NODES * ALPHABET_SIZE entries
// (26624 at the defaults), while o_in_stall stays high.
// A stalled result holds its value until it is taken.
module trie_insert_and_walk_unit
    import trie_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int POOL_NODES    = POOL_NODES_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    localparam int SYM_W        = $clog2(ALPHABET_SIZE),
    localparam int NODE_W       = $clog2(POOL_NODES),
    localparam int CNT_W        = $clog2(POOL_NODES + 1),
    localparam int DEP_W        = NODE_W + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_opcode,
    input  logic                    i_start_req,
    input  logic [SYM_W-1:0]        i_symbol,
    input  logic [NODE_W-1:0]       i_node,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [NODE_W-1:0]       o_result_node,
    output logic signed [DEP_W-1:0] o_depth,
    output logic [COUNT_BITS-1:0]   o_prefix_count,
    output logic [CNT_W-1:0]        o_nodes_used,
    output logic [1:0]              o_status
);

    localparam int CHILD_DEPTH = POOL_NODES * ALPHABET_SIZE;
    localparam int ADDR_W      = $clog2(CHILD_DEPTH);
    localparam int INFO_W      = DEP_W + COUNT_BITS;

    localparam logic [NODE_W-1:0] ROOT_NODE  = NODE_W'(ROOT_ID);
    localparam logic [NODE_W-1:0] SENT_NODE  = NODE_W'(SENTINEL_ID);
    localparam logic [CNT_W-1:0]  FIRST_FREE = CNT_W'(FIRST_FREE_ID);
    localparam logic [CNT_W-1:0]  POOL_FULL  = CNT_W'(POOL_NODES);
    localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(CHILD_DEPTH - 1);
    localparam logic [DEP_W-1:0]  SENT_DEPTH = DEP_W'(SENTINEL_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FAST  = 3'd1;
    localparam logic [2:0] S_CHILD = 3'd2;
    localparam logic [2:0] S_INFO  = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;

    logic [2:0]            r_state, n_state;
    t_opcode               r_op, n_op;
    t_status               r_fast_st, n_fast_st;
    logic [NODE_W-1:0]     r_row, n_row;
    logic [DEP_W-1:0]      r_from_depth, n_from_depth;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [NODE_W-1:0]     r_hit, n_hit;
    logic [NODE_W-1:0]     r_cur_node, n_cur_node;
    logic [DEP_W-1:0]      r_cur_depth, n_cur_depth;
    logic [COUNT_BITS-1:0] r_cur_count, n_cur_count;
    logic [CNT_W-1:0]      r_alloc, n_alloc;
    logic [ADDR_W-1:0]     r_sweep, n_sweep;

    logic                  r_out_valid;
    logic [NODE_W-1:0]     r_out_node;
    logic [DEP_W-1:0]      r_out_depth;
    logic [COUNT_BITS-1:0] r_out_count;
    logic [CNT_W-1:0]      r_out_used;
    t_status               r_out_status;

    logic                  commit;
    logic                  out_free;
    logic [NODE_W-1:0]     res_node;
    logic [DEP_W-1:0]      res_depth;
    logic [COUNT_BITS-1:0] res_count;
    t_status               res_status;

    logic                  child_we, child_re;
    logic [ADDR_W-1:0]     child_waddr, child_raddr;
    logic [NODE_W-1:0]     child_wdata, child_rdata;
    logic                  info_we, info_re;
    logic [NODE_W-1:0]     info_waddr, info_raddr;
    logic [INFO_W-1:0]     info_wdata, info_rdata;

    logic [NODE_W-1:0]     acc_row;
    logic [NODE_W-1:0]     acc_base;
    logic [ADDR_W-1:0]     acc_addr;
    logic                  sym_ok;
    logic                  node_ok;
    logic [NODE_W-1:0]     child_val;
    logic [DEP_W-1:0]      hit_depth;
    logic [COUNT_BITS-1:0] hit_count;
    logic [COUNT_BITS-1:0] hit_count_inc;
    logic [DEP_W-1:0]      new_depth;

    assign out_free = !r_out_valid || !i_out_stall;

    assign acc_row  = i_start_req ? ROOT_NODE : r_cur_node;
    assign acc_base = (i_opcode == OP_INSERT) ? acc_row : i_node;
    assign acc_addr = ADDR_W'(acc_base) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(i_symbol);
    assign sym_ok   = 32'(i_symbol) < 32'(ALPHABET_SIZE);
    assign node_ok  = CNT_W'(i_node) < r_alloc;

    // The sentinel row is never stored: every edge of it leads to the root.
    assign child_val = (r_row == SENT_NODE) ? ROOT_NODE : child_rdata;

    always_comb begin
        if (r_hit == SENT_NODE) begin
            hit_depth = SENT_DEPTH;
            hit_count = '0;
        end else if (r_hit == ROOT_NODE) begin
            hit_depth = '0;
            hit_count = '0;
        end else begin
            hit_depth = info_rdata[INFO_W-1:COUNT_BITS];
            hit_count = info_rdata[COUNT_BITS-1:0];
        end
    end

    assign hit_count_inc = (hit_count == '1) ? hit_count : hit_count + 1'b1;
    assign new_depth     = r_from_depth + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_fast_st    = r_fast_st;
        n_row        = r_row;
        n_from_depth = r_from_depth;
        n_addr       = r_addr;
        n_hit        = r_hit;
        n_cur_node   = r_cur_node;
        n_cur_depth  = r_cur_depth;
        n_cur_count  = r_cur_count;
        n_alloc      = r_alloc;
        n_sweep      = r_sweep;
        commit       = 1'b0;
        res_node     = '0;
        res_depth    = '0;
        res_count    = '0;
        res_status   = ST_OK;
        child_we     = 1'b0;
        child_waddr  = r_addr;
        child_wdata  = r_alloc[NODE_W-1:0];
        child_re     = 1'b0;
        child_raddr  = acc_addr;
        info_we      = 1'b0;
        info_waddr   = r_hit;
        info_wdata   = {hit_depth, hit_count_inc};
        info_re      = 1'b0;
        info_raddr   = i_node;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op         = i_opcode;
                    n_addr       = acc_addr;
                    n_row        = acc_base;
                    n_from_depth = i_start_req ? '0 : r_cur_depth;
                    n_hit        = i_node;
                    n_fast_st    = ST_OK;
                    case (i_opcode)
                        OP_INSERT: begin
                            if (sym_ok) begin
                                child_re = 1'b1;
                                n_state  = S_CHILD;
                            end else begin
                                n_fast_st = ST_SYM;
                                n_state   = S_FAST;
                            end
                        end
                        OP_QCHILD: begin
                            if (!sym_ok) begin
                                n_fast_st = ST_SYM;
                                n_state   = S_FAST;
                            end else if (!node_ok) begin
                                n_fast_st = ST_NODE;
                                n_state   = S_FAST;
                            end else begin
                                child_re = 1'b1;
                                n_state  = S_CHILD;
                            end
                        end
                        OP_QNODE: begin
                            if (!node_ok) begin
                                n_fast_st = ST_NODE;
                                n_state   = S_FAST;
                            end else begin
                                info_re = 1'b1;
                                n_state = S_INFO;
                            end
                        end
                        default: begin
                            n_state = S_FAST;
                        end
                    endcase
                end
            end
            S_FAST: begin
                if (out_free) begin
                    commit     = 1'b1;
                    res_status = r_fast_st;
                    n_state    = S_IDLE;
                    case (r_op)
                        OP_INSERT: begin
                            res_node  = r_cur_node;
                            res_depth = r_cur_depth;
                            res_count = r_cur_count;
                        end
                        OP_CLEAR: begin
                            n_alloc     = FIRST_FREE;
                            n_cur_node  = ROOT_NODE;
                            n_cur_depth = '0;
                            n_cur_count = '0;
                            n_sweep     = '0;
                            n_state     = S_CLEAR;
                        end
                        default: begin
                            res_node = '0;
                        end
                    endcase
                end
            end
            S_CHILD: begin
                if (r_op == OP_INSERT && child_val == '0) begin
                    if (out_free) begin
                        commit  = 1'b1;
                        n_state = S_IDLE;
                        if (r_alloc == POOL_FULL) begin
                            res_node   = r_cur_node;
                            res_depth  = r_cur_depth;
                            res_count  = r_cur_count;
                            res_status = ST_FULL;
                        end else begin
                            child_we    = 1'b1;
                            info_we     = 1'b1;
                            info_waddr  = r_alloc[NODE_W-1:0];
                            info_wdata  = {new_depth, COUNT_BITS'(1)};
                            n_alloc     = r_alloc + 1'b1;
                            n_cur_node  = r_alloc[NODE_W-1:0];
                            n_cur_depth = new_depth;
                            n_cur_count = COUNT_BITS'(1);
                            res_node    = r_alloc[NODE_W-1:0];
                            res_depth   = new_depth;
                            res_count   = COUNT_BITS'(1);
                        end
                    end
                end else begin
                    info_re    = 1'b1;
                    info_raddr = child_val;
                    n_hit      = child_val;
                    n_state    = S_INFO;
                end
            end
            S_INFO: begin
                if (out_free) begin
                    commit    = 1'b1;
                    n_state   = S_IDLE;
                    res_node  = r_hit;
                    res_depth = hit_depth;
                    res_count = hit_count;
                    if (r_op == OP_INSERT) begin
                        info_we     = 1'b1;
                        res_count   = hit_count_inc;
                        n_cur_node  = r_hit;
                        n_cur_depth = hit_depth;
                        n_cur_count = hit_count_inc;
                    end
                end
            end
            S_CLEAR: begin
                child_we    = 1'b1;
                child_waddr = r_sweep;
                child_wdata = '0;
                n_sweep     = r_sweep + 1'b1;
                if (r_sweep == SWEEP_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cur_node  <= ROOT_NODE;
            r_cur_depth <= '0;
            r_cur_count <= '0;
            r_alloc     <= FIRST_FREE;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_node  <= n_cur_node;
            r_cur_depth <= n_cur_depth;
            r_cur_count <= n_cur_count;
            r_alloc     <= n_alloc;
            r_sweep     <= n_sweep;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_fast_st    <= n_fast_st;
        r_row        <= n_row;
        r_from_depth <= n_from_depth;
        r_addr       <= n_addr;
        r_hit        <= n_hit;
        if (commit) begin
            r_out_node   <= res_node;
            r_out_depth  <= res_depth;
            r_out_count  <= res_count;
            r_out_used   <= n_alloc;
            r_out_status <= res_status;
        end
    end

    trie_ram #(
        .WIDTH (NODE_W),
        .DEPTH (CHILD_DEPTH)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (child_we),
        .i_waddr (child_waddr),
        .i_wdata (child_wdata),
        .i_re    (child_re),
        .i_raddr (child_raddr),
        .o_rdata (child_rdata)
    );

    trie_ram #(
        .WIDTH (INFO_W),
        .DEPTH (POOL_NODES)
    ) u_info_ram (
        .i_clk   (i_clk),
        .i_we    (info_we),
        .i_waddr (info_waddr),
        .i_wdata (info_wdata),
        .i_re    (info_re),
        .i_raddr (info_raddr),
        .o_rdata (info_rdata)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_node  = r_out_node;
    assign o_depth        = r_out_depth;
    assign o_prefix_count = r_out_count;
    assign o_nodes_used   = r_out_used;
    assign o_status       = r_out_status;

    a_alloc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc >= FIRST_FREE && r_alloc <= POOL_FULL)
        else $error("Allocation count left its legal range.");

    a_cur_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_cur_node) < r_alloc)
        else $error("Current node is not an allocated node.");

    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alloc != $past(r_alloc) |-> (r_alloc == $past(r_alloc) + 1'b1 ||
                                       r_alloc == FIRST_FREE))
        else $error("Allocation count moved by other than one node or a clear.");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_nodes_used == POOL_FULL)
        else $error("Pool full reported while free nodes remain.");

    a_info_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        info_we |-> info_waddr > ROOT_NODE)
        else $error("Node info write aimed at the sentinel or the root.");

endmodule

@@ hdl/trie_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module trie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
